### hdl/aek_pkg.sv
package aek_pkg;

    localparam int VALUE_W  = 16;
    localparam int TIME_W   = 32;
    localparam int CMD_W    = 2;
    localparam int THR_W    = 16;
    localparam int MULT_W   = 8;
    localparam int DIR_W    = 2;
    localparam int DELTA_W  = VALUE_W + 1;
    localparam int PROD_W   = MULT_W + VALUE_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int NEAR_W   = VALUE_W + 2;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam logic [CMD_W-1:0] CMD_TURN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRESS = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POLL  = 2'd3;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    localparam logic [2:0] REG_MIN_VALUE  = 3'd0;
    localparam logic [2:0] REG_MAX_VALUE  = 3'd1;
    localparam logic [2:0] REG_THRESHOLD  = 3'd2;
    localparam logic [2:0] REG_MULTIPLIER = 3'd3;
    localparam logic [2:0] REG_SPEEDUP_EN = 3'd4;
    localparam logic [2:0] REG_REVERSED   = 3'd5;

    localparam logic signed [NEAR_W-1:0] NEAR_MIN_MARGIN = 18'sd5;

    localparam logic [VALUE_W-1:0] MIN_VALUE_RST  = 16'd0;
    localparam logic [VALUE_W-1:0] MAX_VALUE_RST  = 16'd100;
    localparam logic [THR_W-1:0]   THRESHOLD_RST  = 16'd0;
    localparam logic [MULT_W-1:0]  MULTIPLIER_RST = 8'd1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] min_value;
        logic signed [VALUE_W-1:0] max_value;
        logic [THR_W-1:0]          speedup_threshold_ms;
        logic [MULT_W-1:0]         fast_step;
        logic                      speedup_enabled;
        logic                      reversed;
    } t_cfg;

endpackage

### hdl/aek_if.sv
interface aek_item_if;
    import aek_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;
    logic [TIME_W-1:0]         timestamp_ms;

    modport source (output valid, output command, output value, output timestamp_ms,
                    input ready);
    modport sink   (input valid, input command, input value, input timestamp_ms,
                    output ready);
endinterface

interface aek_result_if;
    import aek_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] knob_value;
    logic                      button_pressed;

    modport source (output valid, output knob_value, output button_pressed, input ready);
    modport sink   (input valid, input knob_value, input button_pressed, output ready);
endinterface

### hdl/aek_apb_regs.sv
module aek_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aek_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [aek_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [aek_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output aek_pkg::t_cfg                     o_cfg
);
    import aek_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_value            <= MIN_VALUE_RST;
            r_cfg.max_value            <= MAX_VALUE_RST;
            r_cfg.speedup_threshold_ms <= THRESHOLD_RST;
            r_cfg.fast_step            <= MULTIPLIER_RST;
            r_cfg.speedup_enabled      <= 1'b0;
            r_cfg.reversed             <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MIN_VALUE:  r_cfg.min_value            <= pwdata[VALUE_W-1:0];
                REG_MAX_VALUE:  r_cfg.max_value            <= pwdata[VALUE_W-1:0];
                REG_THRESHOLD:  r_cfg.speedup_threshold_ms <= pwdata[THR_W-1:0];
                REG_MULTIPLIER: r_cfg.fast_step            <= pwdata[MULT_W-1:0];
                REG_SPEEDUP_EN: r_cfg.speedup_enabled      <= pwdata[0];
                REG_REVERSED:   r_cfg.reversed             <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_MIN_VALUE:  prdata = APB_DATA_W'(unsigned'(r_cfg.min_value));
            REG_MAX_VALUE:  prdata = APB_DATA_W'(unsigned'(r_cfg.max_value));
            REG_THRESHOLD:  prdata = APB_DATA_W'(r_cfg.speedup_threshold_ms);
            REG_MULTIPLIER: prdata = APB_DATA_W'(r_cfg.fast_step);
            REG_SPEEDUP_EN: prdata = APB_DATA_W'(r_cfg.speedup_enabled);
            REG_REVERSED:   prdata = APB_DATA_W'(r_cfg.reversed);
            default:        prdata = '0;
        endcase
    end

endmodule

### hdl/aek_core.sv
module aek_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  aek_pkg::t_cfg i_cfg,
    aek_item_if.sink      i_item,
    aek_result_if.source  o_result
);
    import aek_pkg::*;

    // input register
    logic                      r_s1_valid;
    logic [CMD_W-1:0]          r_s1_cmd;
    logic signed [VALUE_W-1:0] r_s1_value;
    logic [TIME_W-1:0]         r_s1_ts;

    // result register
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_knob;
    logic                      r_out_pressed;

    // knob state
    logic signed [VALUE_W-1:0] r_cur;
    logic signed [VALUE_W-1:0] r_last_raw;
    logic [TIME_W-1:0]         r_ltt;
    logic [DIR_W-1:0]          r_last_dir;
    logic                      r_latch;

    logic                      n_cur_q;
    logic                      adv;
    logic                      s1_fire;

    logic signed [DELTA_W-1:0] delta;
    logic [DELTA_W-1:0]        neg_delta;
    logic [VALUE_W-1:0]        mag;
    logic                      delta_zero;
    logic                      delta_neg;
    logic [DIR_W-1:0]          dir;
    logic                      applied_neg;
    logic signed [NEAR_W-1:0]  cur_near;
    logic signed [NEAR_W-1:0]  min_near;
    logic                      near_min;
    logic                      clr_time;
    logic [TIME_W-1:0]         ltt_eff;
    logic [TIME_W-1:0]         gap;
    logic                      fast;
    logic [PROD_W-1:0]         prod_fast;
    logic [PROD_W-1:0]         prod;
    logic signed [SUM_W-1:0]   cur_ext;
    logic signed [SUM_W-1:0]   prod_ext;
    logic signed [SUM_W-1:0]   min_ext;
    logic signed [SUM_W-1:0]   max_ext;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   sum_lo;
    logic signed [SUM_W-1:0]   sum_cl;

    logic signed [VALUE_W-1:0] n_cur;
    logic signed [VALUE_W-1:0] n_last_raw;
    logic [TIME_W-1:0]         n_ltt;
    logic [DIR_W-1:0]          n_last_dir;
    logic                      n_latch;
    logic                      n_pressed;

    assign adv            = !r_out_valid || o_result.ready;
    assign s1_fire        = r_s1_valid && adv;
    assign i_item.ready   = !r_s1_valid || adv;
    assign o_result.valid          = r_out_valid;
    assign o_result.knob_value     = r_out_knob;
    assign o_result.button_pressed = r_out_pressed;
    assign n_cur_q        = 1'b0;

    // turn arithmetic
    assign delta      = {r_s1_value[VALUE_W-1], r_s1_value} - {r_last_raw[VALUE_W-1], r_last_raw};
    assign neg_delta  = -delta;
    assign delta_neg  = delta[DELTA_W-1];
    assign delta_zero = (delta == '0);
    assign mag        = delta_neg ? neg_delta[VALUE_W-1:0] : delta[VALUE_W-1:0];
    assign dir        = delta_neg ? DIR_DOWN : DIR_UP;
    assign applied_neg = delta_neg ^ i_cfg.reversed;

    assign cur_near = {{2{r_cur[VALUE_W-1]}}, r_cur};
    assign min_near = {{2{i_cfg.min_value[VALUE_W-1]}}, i_cfg.min_value} + NEAR_MIN_MARGIN;
    assign near_min = cur_near <= min_near;

    assign clr_time = ((r_last_dir != DIR_NONE) && (r_last_dir != dir)) ||
                      (near_min && applied_neg);
    assign ltt_eff  = clr_time ? '0 : r_ltt;
    assign gap      = r_s1_ts - ltt_eff;
    assign fast     = i_cfg.speedup_enabled && (ltt_eff != '0) && !near_min &&
                      (gap < TIME_W'(i_cfg.speedup_threshold_ms));

    assign prod_fast = PROD_W'(i_cfg.fast_step) * PROD_W'(mag);
    assign prod      = fast ? prod_fast : PROD_W'(mag);

    assign cur_ext  = {{(SUM_W-VALUE_W){r_cur[VALUE_W-1]}}, r_cur};
    assign prod_ext = {2'b00, prod};
    assign min_ext  = {{(SUM_W-VALUE_W){i_cfg.min_value[VALUE_W-1]}}, i_cfg.min_value};
    assign max_ext  = {{(SUM_W-VALUE_W){i_cfg.max_value[VALUE_W-1]}}, i_cfg.max_value};
    assign sum      = applied_neg ? (cur_ext - prod_ext) : (cur_ext + prod_ext);
    assign sum_lo   = (sum < min_ext) ? min_ext : sum;
    assign sum_cl   = (sum_lo > max_ext) ? max_ext : sum_lo;

    always_comb begin
        n_cur      = r_cur;
        n_last_raw = r_last_raw;
        n_ltt      = r_ltt;
        n_last_dir = r_last_dir;
        n_latch    = r_latch;
        n_pressed  = n_cur_q;
        unique case (r_s1_cmd)
            CMD_TURN: begin
                n_last_raw = r_s1_value;
                if (!delta_zero) begin
                    n_cur      = sum_cl[VALUE_W-1:0];
                    n_ltt      = r_s1_ts;
                    n_last_dir = dir;
                end
            end
            CMD_SET: begin
                n_cur      = r_s1_value;
                n_last_raw = r_s1_value;
            end
            CMD_PRESS: begin
                n_latch = 1'b1;
            end
            CMD_POLL: begin
                n_pressed = r_latch;
                n_latch   = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_last_raw  <= '0;
            r_ltt       <= '0;
            r_last_dir  <= DIR_NONE;
            r_latch     <= 1'b0;
        end else begin
            if (i_item.valid && i_item.ready) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                r_cur      <= n_cur;
                r_last_raw <= n_last_raw;
                r_ltt      <= n_ltt;
                r_last_dir <= n_last_dir;
                r_latch    <= n_latch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_s1_cmd   <= i_item.command;
            r_s1_value <= i_item.value;
            r_s1_ts    <= i_item.timestamp_ms;
        end
        if (s1_fire) begin
            r_out_knob    <= n_cur;
            r_out_pressed <= n_pressed;
        end
    end

endmodule

### hdl/accelerated_encoder_knob.sv
// An accepted input goes into the input register, then into the result register.
// Throughput: one transaction per cycle unless the result side stalls; the knob
// state is updated in a single pass between the input and result registers.
// Reset: synchronous, active low; clears knob state, button latch and valid flags,
// and loads the register defaults (min 0, max 100, multiplier 1).
module accelerated_encoder_knob (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aek_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [aek_pkg::APB_DATA_W-1:0] pwdata,
    output logic [aek_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    aek_item_if.sink                       i_item,
    aek_result_if.source                   o_result
);
    import aek_pkg::*;

    t_cfg cfg;

    aek_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    aek_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

### tb/accelerated_encoder_knob_test.sv
`timescale 1ns / 1ps

module accelerated_encoder_knob_test;
    import aek_pkg::*;

    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 100000;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] val;
        logic [TIME_W-1:0]         stamp;
    } t_encoder_event;

    typedef struct {
        logic signed [VALUE_W-1:0] knob;
        logic                      pressed;
    } t_knob_reading;

    typedef struct {
        int lo;
        int hi;
        int thr;
        int mult;
        int en;
        int rev;
    } t_cfg_set;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    aek_item_if   knob_in ();
    aek_result_if knob_out ();

    accelerated_encoder_knob i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_item   (knob_in),
        .o_result (knob_out)
    );

    // predictor configuration
    logic signed [VALUE_W-1:0] cfg_min;
    logic signed [VALUE_W-1:0] cfg_max;
    logic [THR_W-1:0]          cfg_thr;
    logic [MULT_W-1:0]         cfg_mult;
    logic                      cfg_fast_en;
    logic                      cfg_rev;

    // predictor state
    logic signed [VALUE_W-1:0] knob_now;
    logic signed [VALUE_W-1:0] raw_last;
    logic [TIME_W-1:0]         turn_stamp;
    logic [DIR_W-1:0]          dir_last;
    logic                      press_held;

    t_encoder_event pending_events[$];
    t_knob_reading  knob_expected[$];
    t_encoder_event next_event;
    t_encoder_event taken_event;
    t_knob_reading  predicted;
    t_knob_reading  want;

    logic signed [VALUE_W-1:0] raw_cursor;
    logic [TIME_W-1:0]         clock_cursor;
    logic                      sweep_up;

    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        hold_go;
    logic        rx_hold;
    int          failures;
    int unsigned cycle_count;

    function automatic t_knob_reading predict_knob(t_encoder_event ev);
        t_knob_reading    r;
        int               delta;
        int               mag;
        int               step;
        int               applied;
        int               nxt;
        logic [DIR_W-1:0] dir;
        logic             near_min;
        logic [TIME_W-1:0] gap;
        r.pressed = 1'b0;
        case (ev.cmd)
            CMD_TURN: begin
                delta = int'(ev.val) - int'(raw_last);
                raw_last = ev.val;
                if (delta != 0) begin
                    dir = (delta > 0) ? DIR_UP : DIR_DOWN;
                    applied = (delta > 0) ? 1 : -1;
                    if (cfg_rev) begin
                        applied = -applied;
                    end
                    near_min = int'(knob_now) <= int'(cfg_min) + int'(NEAR_MIN_MARGIN);
                    if ((dir_last != DIR_NONE && dir_last != dir) || (near_min && applied < 0)) begin
                        turn_stamp = '0;
                    end
                    dir_last = dir;
                    step = 1;
                    if (cfg_fast_en && turn_stamp != '0 && !near_min) begin
                        gap = ev.stamp - turn_stamp;
                        if (gap < {16'd0, cfg_thr}) begin
                            step = int'(cfg_mult);
                        end
                    end
                    mag = (delta < 0) ? -delta : delta;
                    nxt = int'(knob_now) + applied * step * mag;
                    if (nxt < int'(cfg_min)) begin
                        nxt = int'(cfg_min);
                    end
                    if (nxt > int'(cfg_max)) begin
                        nxt = int'(cfg_max);
                    end
                    knob_now = 16'(nxt);
                    turn_stamp = ev.stamp;
                end
            end
            CMD_SET: begin
                knob_now = ev.val;
                raw_last = ev.val;
            end
            CMD_PRESS: begin
                press_held = 1'b1;
            end
            default: begin
                r.pressed = press_held;
                press_held = 1'b0;
            end
        endcase
        r.knob = knob_now;
        return r;
    endfunction

    function automatic t_encoder_event random_event();
        t_encoder_event ev;
        int             roll;
        int             stride;
        roll = $urandom_range(99);
        ev.val = 16'($urandom);
        ev.stamp = $urandom;
        if (roll < 72) begin
            ev.cmd = CMD_TURN;
            if ($urandom_range(99) < 15) begin
                sweep_up = !sweep_up;
            end
            stride = ($urandom_range(9) == 0) ? $urandom_range(400) : $urandom_range(3);
            if ($urandom_range(49) != 0) begin
                ev.val = sweep_up ? 16'(raw_cursor + stride) : 16'(raw_cursor - stride);
            end
            case ($urandom_range(19))
                0: ev.stamp = '0;
                1: ;
                2: ev.stamp = clock_cursor + $urandom_range(100000);
                default: ev.stamp = clock_cursor + $urandom_range(70);
            endcase
            clock_cursor = ev.stamp;
            raw_cursor = ev.val;
        end else if (roll < 80) begin
            ev.cmd = CMD_SET;
            if ($urandom_range(1) == 0) begin
                ev.val = 16'(cfg_min + $urandom_range(12));
            end
            raw_cursor = ev.val;
        end else if (roll < 90) begin
            ev.cmd = CMD_PRESS;
        end else begin
            ev.cmd = CMD_POLL;
        end
        return ev;
    endfunction

    function automatic void queue_event(logic [CMD_W-1:0] cmd, int val, logic [TIME_W-1:0] stamp);
        t_encoder_event ev;
        ev.cmd = cmd;
        ev.val = 16'(val);
        ev.stamp = stamp;
        pending_events.push_back(ev);
    endfunction

    function automatic t_cfg_set phase_setting(int idx);
        t_cfg_set s;
        case (idx)
            0: s = '{0, 100, 0, 1, 0, 0};
            1: s = '{-500, 500, 40, 3, 1, 0};
            2: s = '{-32768, 32767, 65535, 255, 1, 0};
            3: s = '{-32768, 32767, 100, 0, 1, 1};
            4: s = '{32767, -32768, 20, 2, 1, 0};
            5: s = '{-100, 100, 30, 7, 1, 1};
            6: s = '{0, 0, 65535, 128, 1, 0};
            7: s = '{-20000, 20000, 1, 255, 0, 1};
            default: begin
                s.lo = int'($urandom_range(65535)) - 32768;
                s.hi = int'($urandom_range(65535)) - 32768;
                s.thr = $urandom_range(65535);
                s.mult = $urandom_range(255);
                s.en = $urandom_range(1);
                s.rev = $urandom_range(1);
            end
        endcase
        return s;
    endfunction

    function automatic void report_mismatch(string field, string want_s, string got_s);
        failures++;
        $display("%0t ns: %s expected %s actual %s", $time, field, want_s, got_s);
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_VALUE:  cfg_min = data[VALUE_W-1:0];
            REG_MAX_VALUE:  cfg_max = data[VALUE_W-1:0];
            REG_THRESHOLD:  cfg_thr = data[THR_W-1:0];
            REG_MULTIPLIER: cfg_mult = data[MULT_W-1:0];
            REG_SPEEDUP_EN: cfg_fast_en = data[0];
            REG_REVERSED:   cfg_rev = data[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_setting(t_cfg_set s);
        apb_write(REG_MIN_VALUE, 32'(s.lo));
        apb_write(REG_MAX_VALUE, 32'(s.hi));
        apb_write(REG_THRESHOLD, 32'(s.thr));
        apb_write(REG_MULTIPLIER, 32'(s.mult));
        apb_write(REG_SPEEDUP_EN, 32'(s.en));
        apb_write(REG_REVERSED, 32'(s.rev));
    endtask

    task automatic wait_knob_idle();
        while (pending_events.size() != 0 || knob_in.valid || knob_expected.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: offer queued transactions, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            knob_in.valid <= 1'b0;
        end else begin
            if (knob_in.valid && knob_in.ready) begin
                taken_event.cmd = knob_in.command;
                taken_event.val = knob_in.value;
                taken_event.stamp = knob_in.timestamp_ms;
                predicted = predict_knob(taken_event);
                knob_expected.push_back(predicted);
            end
            if (!knob_in.valid || knob_in.ready) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_event = pending_events.pop_front();
                    knob_in.valid        <= 1'b1;
                    knob_in.command      <= next_event.cmd;
                    knob_in.value        <= next_event.val;
                    knob_in.timestamp_ms <= next_event.stamp;
                end else begin
                    knob_in.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            knob_out.ready <= 1'b0;
        end else begin
            if (knob_out.valid && knob_out.ready) begin
                if (knob_expected.size() == 0) begin
                    report_mismatch("result", "none",
                                    $sformatf("knob %0d button %0b",
                                              knob_out.knob_value, knob_out.button_pressed));
                end else begin
                    want = knob_expected.pop_front();
                    if (knob_out.knob_value !== want.knob) begin
                        report_mismatch("knob_value", $sformatf("%0d", want.knob),
                                        $sformatf("%0d", knob_out.knob_value));
                    end
                    if (knob_out.button_pressed !== want.pressed) begin
                        report_mismatch("button_pressed", $sformatf("%0b", want.pressed),
                                        $sformatf("%0b", knob_out.button_pressed));
                    end
                end
            end
            knob_out.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // hold off the receiver so the block backs up
    initial begin
        rx_hold <= 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        knob_in.valid        = 1'b0;
        knob_in.command      = CMD_TURN;
        knob_in.value        = '0;
        knob_in.timestamp_ms = '0;
        knob_out.ready       = 1'b0;
        cfg_min              = MIN_VALUE_RST;
        cfg_max              = MAX_VALUE_RST;
        cfg_thr              = THRESHOLD_RST;
        cfg_mult             = MULTIPLIER_RST;
        cfg_fast_en          = 1'b0;
        cfg_rev              = 1'b0;
        knob_now             = '0;
        raw_last             = '0;
        turn_stamp           = '0;
        dir_last             = DIR_NONE;
        press_held           = 1'b0;
        raw_cursor           = '0;
        clock_cursor         = '0;
        sweep_up             = 1'b1;
        tx_idle_pct          = 33;
        rx_idle_pct          = 48;
        hold_go              = 1'b0;
        failures             = 0;
        cycle_count          = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default registers: clamping, zero delta, set outside bounds, button latch
        queue_event(CMD_TURN, 10, 32'd100);
        queue_event(CMD_TURN, 7, 32'd105);
        queue_event(CMD_TURN, 7, 32'd110);
        queue_event(CMD_SET, 32767, 32'd0);
        queue_event(CMD_TURN, -32768, 32'd200);
        queue_event(CMD_TURN, 32767, 32'hFFFF_FFFF);
        queue_event(CMD_SET, -32768, 32'hFFFF_FFFF);
        queue_event(CMD_PRESS, 16'h5555, 32'hAAAA_AAAA);
        queue_event(CMD_POLL, 0, 32'd0);
        queue_event(CMD_POLL, -1, 32'hFFFF_FFFF);
        queue_event(CMD_PRESS, 0, 32'd0);
        queue_event(CMD_PRESS, 0, 32'd0);
        queue_event(CMD_POLL, 16'hAAAA, 32'h5555_5555);
        wait_knob_idle();

        // acceleration, time zero, timestamp wrap
        apply_setting('{-1000, 1000, 50, 4, 1, 0});
        queue_event(CMD_SET, 0, 32'd0);
        queue_event(CMD_TURN, 1, 32'd1000);
        queue_event(CMD_TURN, 3, 32'd1010);
        queue_event(CMD_TURN, 4, 32'd0);
        queue_event(CMD_TURN, 5, 32'd5);
        queue_event(CMD_TURN, 6, 32'hFFFF_FFF0);
        queue_event(CMD_TURN, 8, 32'h0000_0010);
        wait_knob_idle();

        // zero multiplier on a fast turn
        apb_write(REG_MULTIPLIER, 32'd0);
        queue_event(CMD_TURN, 9, 32'h0000_0018);
        wait_knob_idle();

        // reversed direction, downward near minimum, crossed bounds
        apb_write(REG_REVERSED, 32'd1);
        apb_write(REG_MIN_VALUE, 32'd30);
        apb_write(REG_MAX_VALUE, -32'sd30);
        queue_event(CMD_TURN, 10, 32'h0000_0020);
        queue_event(CMD_TURN, 8, 32'h0000_0028);
        wait_knob_idle();

        for (int p = 0; p < PHASES; p++) begin
            tx_idle_pct = (p < 3) ? 33 : (p < 6) ? 48 : 0;
            rx_idle_pct = (p < 3) ? 48 : (p < 6) ? 33 : 0;
            apply_setting(phase_setting(p));
            if (p == 6) begin
                hold_go = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) pending_events.push_back(random_event());
            wait_knob_idle();
        end

        repeat (8) @(posedge i_clk);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
